// ===== sv/cpce_pkg.sv =====
package cpce_pkg;

   // fixed field widths of the pixel and result beats
   localparam int SAMPLE_WIDTH    = 16;
   localparam int BASE_WIDTH      = 16;
   localparam int VALUE_WIDTH     = 17;
   localparam int SERIES_WIDTH    = 17;
   localparam int KIND_WIDTH      = 2;
   localparam int MASK_WIDTH      = 4;
   localparam int OFFSET_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   // cordic datapath
   localparam int GUARD_BITS   = 16;
   localparam int ANGLE_WIDTH  = 32;
   localparam int PHASE_WIDTH  = 16;
   localparam int COORD_WIDTH  = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int GAIN_WIDTH   = 30;
   localparam int GAIN_FRAC    = 30;
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;

   localparam int ITEM_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH  = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPONENT_MASK   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REAL_IMAG_OFFSET = 4'd1;

   localparam logic [MASK_WIDTH-1:0]   MASK_RESET   = 4'b0001;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = 16'd0;

   localparam logic [KIND_WIDTH-1:0] KIND_MAG   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_REAL  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_IMAG  = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_PHASE = 2'd3;

   localparam logic [SERIES_WIDTH-1:0] SERIES_STEP_REAL  = 17'd1000;
   localparam logic [SERIES_WIDTH-1:0] SERIES_STEP_IMAG  = 17'd2000;
   localparam logic [SERIES_WIDTH-1:0] SERIES_STEP_PHASE = 17'd3000;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] re_part;
      logic signed [SAMPLE_WIDTH-1:0] im_part;
      logic [BASE_WIDTH-1:0]          series_base;
      logic                           last_pixel;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] comp_value;
      logic [KIND_WIDTH-1:0]         comp_kind;
      logic [SERIES_WIDTH-1:0]       series_out;
      logic                          image_end;
      logic                          run_last;
   } rsp_type;

   // what travels alongside the cordic pipeline
   typedef struct packed {
      logic [BASE_WIDTH-1:0]         series_base;
      logic                          last_pixel;
      logic [MASK_WIDTH-1:0]         mask;
      logic signed [VALUE_WIDTH-1:0] real_val;
      logic signed [VALUE_WIDTH-1:0] imag_val;
   } side_type;

   // classified pixel between front and back
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] re_part;
      logic signed [SAMPLE_WIDTH-1:0] im_part;
      side_type                       side;
   } item_type;

   // arctan(2^-i) in turns scaled by 2^32
   function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input logic [4:0] idx);
      logic [ANGLE_WIDTH-1:0] a;
      case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   function automatic logic [SERIES_WIDTH-1:0] series_step(input logic [KIND_WIDTH-1:0] kind);
      logic [SERIES_WIDTH-1:0] s;
      case (kind)
         KIND_REAL:  s = SERIES_STEP_REAL;
         KIND_IMAG:  s = SERIES_STEP_IMAG;
         KIND_PHASE: s = SERIES_STEP_PHASE;
         default:    s = '0;
      endcase
      return s;
   endfunction

endpackage

// ===== sv/complex_pixel_component_extract_top.sv =====
// Complex pixel component extractor. Each pixel beat pushed on req_ yields one
// result beat per bit set in component_mask, in the order magnitude, real,
// imaginary, phase; run_last marks the final beat of the pixel, and a pixel with
// an empty mask gives none. Magnitude and phase come from a pipelined CORDIC of
// CORDIC_STEPS stages followed by a two-stage gain multiply. The pipeline takes
// a new pixel every cycle while the hold stage ahead of the result queue is free;
// the sustained rate is set by the result port, which moves one beat per cycle
// while the result queue has room, one beat per selected component of a pixel.
// Four-entry queues sit at the pixel input and at the result output. Registers
// take effect on the next pixel accepted and should be written only while no
// pixel is in flight.
module complex_pixel_component_extract_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  cpce_pkg::req_type                     req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output cpce_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cpce_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpce_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import cpce_pkg::*;

   localparam int ITEM_W = $bits(item_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic              item_push, item_full, item_pop, item_empty;
   item_type          front_item, back_item;
   logic [ITEM_W-1:0] back_item_bits;
   logic              out_push, out_full;
   rsp_type           out_data;
   logic [RSP_W-1:0]  rsp_bits;

   cpce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item_push (item_push),
      .item_data (front_item),
      .item_full (item_full)
   );

   cpce_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (ITEM_QUEUE_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .din   (front_item),
      .full  (item_full),
      .pop   (item_pop),
      .dout  (back_item_bits),
      .empty (item_empty)
   );

   assign back_item = item_type'(back_item_bits);

   cpce_back #(
      .STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_data  (back_item),
      .item_pop   (item_pop),
      .rsp_push   (out_push),
      .rsp_data   (out_data),
      .rsp_full   (out_full)
   );

   cpce_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

// ===== sv/cpce_queue.sv =====
module cpce_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// ===== sv/cpce_front.sv =====
module cpce_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  cpce_pkg::req_type                      req_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cpce_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cpce_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic                                   item_push,
   output cpce_pkg::item_type                     item_data,
   input  logic                                   item_full
);

   import cpce_pkg::*;

   localparam int SUM_W = SAMPLE_WIDTH + 2;

   logic [MASK_WIDTH-1:0]          mask_ff, mask_in;
   logic signed [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic signed [SUM_W-1:0]        re_sum, im_sum;

   function automatic logic signed [VALUE_WIDTH-1:0] clamp_value(
      input logic signed [SUM_W-1:0] v);
      logic signed [VALUE_WIDTH-1:0] r;
      // fits when the top bits all copy the sign
      if ((v[SUM_W-1:VALUE_WIDTH-1] == '0) || (v[SUM_W-1:VALUE_WIDTH-1] == '1)) begin
         r = v[VALUE_WIDTH-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_full  = item_full;
   assign item_push = req_push && !item_full;

   always_comb begin
      mask_in   = mask_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMPONENT_MASK:   mask_in = csr_wdata[MASK_WIDTH-1:0];
            CSR_REAL_IMAG_OFFSET: offset_in = csr_wdata[OFFSET_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= MASK_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         mask_ff   <= mask_in;
         offset_ff <= offset_in;
      end
   end

   assign re_sum = SUM_W'(req_data.re_part) + SUM_W'(offset_ff);
   assign im_sum = SUM_W'(req_data.im_part) + SUM_W'(offset_ff);

   always_comb begin
      item_data.re_part          = req_data.re_part;
      item_data.im_part          = req_data.im_part;
      item_data.side.series_base = req_data.series_base;
      item_data.side.last_pixel  = req_data.last_pixel;
      item_data.side.mask        = mask_ff;
      item_data.side.real_val    = clamp_value(re_sum);
      item_data.side.imag_val    = clamp_value(im_sum);
   end

endmodule

// ===== sv/cpce_cordic.sv =====
module cpce_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  cpce_pkg::item_type                   in_item,
   output logic                                 out_valid,
   output logic [cpce_pkg::PHASE_WIDTH-1:0]     out_mag,
   output logic [cpce_pkg::PHASE_WIDTH-1:0]     out_phase,
   output cpce_pkg::side_type                   out_side
);

   import cpce_pkg::*;

   localparam int XW    = COORD_WIDTH;
   localparam int EXT_W = XW - SAMPLE_WIDTH - GUARD_BITS;
   localparam int HW    = XW - GUARD_BITS;
   localparam int PHW   = HW + GAIN_WIDTH;
   localparam int PLW   = GUARD_BITS + GAIN_WIDTH;
   localparam int SUM_W = PHW + 1;
   localparam int MW    = SUM_W - GAIN_FRAC;
   localparam int LAST  = STEPS + 2;

   localparam logic [SUM_W-1:0]       ROUND_HALF = SUM_W'(1) << (GAIN_FRAC - 1);
   localparam logic [ANGLE_WIDTH-1:0] PHASE_BIAS = 32'h8000_8000;
   localparam logic [PHASE_WIDTH-1:0] ZERO_PHASE = 16'h8000;

   logic [LAST:0]                valid_ff;
   logic signed [XW-1:0]         x_ff [0:STEPS];
   logic signed [XW-1:0]         y_ff [0:STEPS];
   logic [ANGLE_WIDTH-1:0]       z_ff [0:STEPS];
   logic                         zero_ff [0:STEPS];
   side_type                     side_ff [0:LAST];

   logic signed [XW-1:0]         x_in [1:STEPS];
   logic signed [XW-1:0]         y_in [1:STEPS];
   logic [ANGLE_WIDTH-1:0]       z_in [1:STEPS];
   logic signed [XW-1:0]         xs [0:STEPS-1];
   logic signed [XW-1:0]         ys [0:STEPS-1];

   logic signed [XW-1:0]         re_ext, im_ext, x0, y0;
   logic [ANGLE_WIDTH-1:0]       z0;
   logic                         zero0, neg0;

   logic [HW-1:0]                mag_hi;
   logic [GUARD_BITS-1:0]        mag_lo;
   logic [PHW-1:0]               prod_hi_ff, prod_hi_in;
   logic [PLW-1:0]               prod_lo_ff, prod_lo_in;
   logic [PHASE_WIDTH-1:0]       phase1_ff, phase1_in, phase2_ff;
   logic [ANGLE_WIDTH-1:0]       z_biased;
   logic [SUM_W-1:0]             mag_sum;
   logic [MW-1:0]                mag_wide;
   logic [PHASE_WIDTH-1:0]       mag_ff, mag_in;

   // pre-rotation by half a turn when the real part is negative
   assign re_ext = {{EXT_W{in_item.re_part[SAMPLE_WIDTH-1]}}, in_item.re_part,
                    {GUARD_BITS{1'b0}}};
   assign im_ext = {{EXT_W{in_item.im_part[SAMPLE_WIDTH-1]}}, in_item.im_part,
                    {GUARD_BITS{1'b0}}};
   assign neg0   = in_item.re_part[SAMPLE_WIDTH-1];
   assign x0     = neg0 ? -re_ext : re_ext;
   assign y0     = neg0 ? -im_ext : im_ext;
   assign z0     = neg0 ? 32'h8000_0000 : '0;
   assign zero0  = (in_item.re_part == '0) && (in_item.im_part == '0);

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         xs[k] = x_ff[k] >>> k;
         ys[k] = y_ff[k] >>> k;
         if (!y_ff[k][XW-1]) begin
            x_in[k+1] = x_ff[k] + ys[k];
            y_in[k+1] = y_ff[k] - xs[k];
            z_in[k+1] = z_ff[k] + atan_turn(5'(k));
         end else begin
            x_in[k+1] = x_ff[k] - ys[k];
            y_in[k+1] = y_ff[k] + xs[k];
            z_in[k+1] = z_ff[k] - atan_turn(5'(k));
         end
      end
   end

   // gain correction split into high and low parts of x
   assign mag_hi     = x_ff[STEPS][XW-1:GUARD_BITS];
   assign mag_lo     = x_ff[STEPS][GUARD_BITS-1:0];
   assign prod_hi_in = mag_hi * GAIN_Q30;
   assign prod_lo_in = mag_lo * GAIN_Q30;
   assign z_biased   = z_ff[STEPS] + PHASE_BIAS;
   assign phase1_in  = zero_ff[STEPS] ? ZERO_PHASE : z_biased[ANGLE_WIDTH-1:GUARD_BITS];

   assign mag_sum  = SUM_W'(prod_hi_ff) + SUM_W'(prod_lo_ff >> GUARD_BITS) + ROUND_HALF;
   assign mag_wide = mag_sum[SUM_W-1:GAIN_FRAC];
   assign mag_in   = (mag_wide[MW-1:PHASE_WIDTH] != '0) ? '1 : mag_wide[PHASE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x0;
         y_ff[0]    <= y0;
         z_ff[0]    <= z0;
         zero_ff[0] <= zero0;
         side_ff[0] <= in_item.side;
         for (int k = 1; k <= STEPS; k++) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            zero_ff[k] <= zero_ff[k-1];
         end
         for (int k = 1; k <= LAST; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
         phase1_ff  <= phase1_in;
         phase2_ff  <= phase1_ff;
         mag_ff     <= mag_in;
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_mag   = mag_ff;
   assign out_phase = phase2_ff;
   assign out_side  = side_ff[LAST];

   // x starts non-negative and only grows; a sign flip means the coordinate overflowed
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STEPS] |-> !x_ff[STEPS][XW-1])
      else $error("cordic x coordinate went negative");

endmodule

// ===== sv/cpce_back.sv =====
module cpce_back #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_empty,
   input  cpce_pkg::item_type  item_data,
   output logic                item_pop,
   output logic                rsp_push,
   output cpce_pkg::rsp_type   rsp_data,
   input  logic                rsp_full
);

   import cpce_pkg::*;

   logic                     advance;
   logic                     cord_valid;
   logic [PHASE_WIDTH-1:0]   cord_mag, cord_phase;
   side_type                 cord_side;

   logic                     hold_valid_ff, hold_valid_in;
   logic [MASK_WIDTH-1:0]    pend_ff, pend_in;
   logic [PHASE_WIDTH-1:0]   hold_mag_ff, hold_phase_ff;
   side_type                 hold_side_ff;

   logic [MASK_WIDTH-1:0]    sel, rest;
   logic [KIND_WIDTH-1:0]    kind;
   logic                     is_last, emit, hold_free;

   cpce_cordic #(
      .STEPS(STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (item_pop),
      .in_item   (item_data),
      .out_valid (cord_valid),
      .out_mag   (cord_mag),
      .out_phase (cord_phase),
      .out_side  (cord_side)
   );

   // lowest pending component goes first
   assign sel     = pend_ff & (~pend_ff + 1'b1);
   assign rest    = pend_ff & ~sel;
   assign is_last = (rest == '0);

   always_comb begin
      if (pend_ff[0]) begin
         kind = KIND_MAG;
      end else if (pend_ff[1]) begin
         kind = KIND_REAL;
      end else if (pend_ff[2]) begin
         kind = KIND_IMAG;
      end else begin
         kind = KIND_PHASE;
      end
   end

   assign emit      = hold_valid_ff && (pend_ff != '0) && !rsp_full;
   assign hold_free = !hold_valid_ff || (pend_ff == '0) || (emit && is_last);
   assign advance   = hold_free;
   assign item_pop  = advance && !item_empty;
   assign rsp_push  = emit;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      pend_in       = pend_ff;
      if (hold_free) begin
         hold_valid_in = cord_valid;
         pend_in       = cord_valid ? cord_side.mask : '0;
      end else if (emit) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         pend_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_free) begin
         hold_mag_ff   <= cord_mag;
         hold_phase_ff <= cord_phase;
         hold_side_ff  <= cord_side;
      end
   end

   always_comb begin
      case (kind)
         KIND_MAG:   rsp_data.comp_value = {1'b0, hold_mag_ff};
         KIND_REAL:  rsp_data.comp_value = hold_side_ff.real_val;
         KIND_IMAG:  rsp_data.comp_value = hold_side_ff.imag_val;
         default:    rsp_data.comp_value = {1'b0, hold_phase_ff};
      endcase
      rsp_data.comp_kind  = kind;
      rsp_data.series_out = {1'b0, hold_side_ff.series_base} + series_step(kind);
      rsp_data.image_end  = hold_side_ff.last_pixel;
      rsp_data.run_last   = is_last;
   end

   a_pend_needs_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> hold_valid_ff)
      else $error("pending components without a held pixel");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      cord_valid && !hold_free |=> cord_valid && $stable(cord_side) && $stable(cord_mag))
      else $error("cordic output changed while stalled");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      emit && is_last && !cord_valid |=> !hold_valid_ff)
      else $error("hold stage not released after last beat");

endmodule

// ===== tb/complex_pixel_component_extract_top_test.sv =====
`timescale 1ns / 100ps

module complex_pixel_component_extract_top_test;

   import cpce_pkg::*;

   localparam int ROTATIONS     = 16;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 40;

   localparam logic [MASK_WIDTH-1:0] MASK_NONE   = 4'b0000;
   localparam logic [MASK_WIDTH-1:0] MASK_ALL    = 4'b1111;
   localparam logic [MASK_WIDTH-1:0] MASK_PARTS  = 4'b0110;
   localparam logic [MASK_WIDTH-1:0] MASK_POLAR  = 4'b1001;
   localparam logic [MASK_WIDTH-1:0] MASK_PHASE  = 4'b1000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'd7;

   // arctan(2^-i) in turns scaled by 2^32, entry 15 first
   localparam logic [15:0][31:0] ARCTAN_TURNS = {
      32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
      32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
      32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
      32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
   };
   localparam longint unsigned AMP_GAIN = 64'd652032874;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic [MASK_WIDTH-1:0] mask_setting = MASK_RESET;
   logic signed [OFFSET_WIDTH-1:0] offset_setting = OFFSET_RESET;

   rsp_type expected_beats[$];
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit rsp_hold = 1'b0;
   int mismatch_count = 0;
   int beats_checked = 0;
   int pixels_sent = 0;
   int csr_writes = 0;
   int full_cycles = 0;
   int cycle_count = 0;

   complex_pixel_component_extract_top #(
      .CORDIC_STEPS(ROTATIONS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clamp_value(input longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // vectoring cordic: magnitude and phase with arg + pi scaled to 2^16 per turn
   function automatic void cordic_polar(input longint re, input longint im,
                                        output longint mag, output logic [15:0] phase);
      longint x, y, xs, ys;
      logic [31:0] z, turn;
      longint unsigned ux, hi, lo, prod;
      int step;
      if (re == 0 && im == 0) begin
         mag = 0;
         phase = 16'd32768;
         return;
      end
      x = re * 65536;
      y = im * 65536;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h80000000;
      end
      for (step = 0; step < ROTATIONS; step++) begin
         xs = x >>> step;
         ys = y >>> step;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_TURNS[step];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_TURNS[step];
         end
      end
      ux = x;
      hi = ux >> 16;
      lo = ux & 64'hFFFF;
      prod = (hi * AMP_GAIN + ((lo * AMP_GAIN) >> 16) + (64'd1 << 29)) >> 30;
      mag = (prod > 65535) ? 65535 : longint'(prod);
      turn = z + 32'h80008000;
      phase = turn[31:16];
   endfunction

   function automatic void predict_components(input req_type px);
      rsp_type beat;
      longint mag, part;
      logic [15:0] phase;
      logic [KIND_WIDTH-1:0] kind;
      logic [SERIES_WIDTH-1:0] step;
      int k;
      cordic_polar(px.re_part, px.im_part, mag, phase);
      for (k = 0; k < 4; k++) begin
         if (mask_setting[k]) begin
            kind = KIND_WIDTH'(k);
            case (kind)
               KIND_MAG: begin
                  part = mag;
                  step = '0;
               end
               KIND_REAL: begin
                  part = clamp_value(longint'(px.re_part) + longint'(offset_setting));
                  step = SERIES_STEP_REAL;
               end
               KIND_IMAG: begin
                  part = clamp_value(longint'(px.im_part) + longint'(offset_setting));
                  step = SERIES_STEP_IMAG;
               end
               default: begin
                  part = phase;
                  step = SERIES_STEP_PHASE;
               end
            endcase
            beat.comp_value = VALUE_WIDTH'(part);
            beat.comp_kind = kind;
            beat.series_out = {1'b0, px.series_base} + step;
            beat.image_end = px.last_pixel;
            beat.run_last = ((mask_setting >> (k + 1)) == '0);
            expected_beats.push_back(beat);
         end
      end
   endfunction

   function automatic req_type make_pixel(input int re, input int im, input int base,
                                          input bit last);
      req_type px;
      px.re_part = SAMPLE_WIDTH'(re);
      px.im_part = SAMPLE_WIDTH'(im);
      px.series_base = BASE_WIDTH'(base);
      px.last_pixel = last;
      return px;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.re_part = pick_sample();
      px.im_part = pick_sample();
      px.series_base = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                                 : 16'($urandom);
      px.last_pixel = ($urandom_range(3) == 0);
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at result beat %0d: %s", beats_checked, msg);
      mismatch_count++;
   endtask

   // pixel beat out; push is left high so back-to-back pixels need no gap
   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full);
      predict_components(px);
      pixels_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_COMPONENT_MASK)
         mask_setting = value[MASK_WIDTH-1:0];
      else if (index == CSR_REAL_IMAG_OFFSET)
         offset_setting = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // also covers pixels with an empty mask still in the pipeline
   task automatic wait_for_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_beats.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_values();
      send_pixel(make_pixel(3, 4, 10, 1'b0));
      send_pixel(make_pixel(-32768, -32768, 11, 1'b1));
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      write_register(CSR_COMPONENT_MASK, 16'(MASK_ALL));
      write_register(CSR_REAL_IMAG_OFFSET, 16'h0000);
      send_pixel(make_pixel(32767, 32767, 65535, 1'b1));
      send_pixel(make_pixel(-32768, -32768, 0, 1'b0));
      send_pixel(make_pixel(-32768, 0, 65535, 1'b0));
      send_pixel(make_pixel(0, -32768, 1234, 1'b1));
      send_pixel(make_pixel(32767, -32768, 64535, 1'b0));
      // zero vector
      send_pixel(make_pixel(0, 0, 7, 1'b0));
      // negative real axis: arg + pi is a full turn and wraps
      send_pixel(make_pixel(-1, 0, 8, 1'b0));
      send_pixel(make_pixel(-5, -1, 9, 1'b0));
      send_pixel(make_pixel(0, 1, 62535, 1'b1));
      wait_for_results();
   endtask

   task automatic test_offset_extremes();
      write_register(CSR_COMPONENT_MASK, 16'(MASK_PARTS));
      write_register(CSR_REAL_IMAG_OFFSET, 16'h7FFF);
      send_pixel(make_pixel(32767, 32767, 100, 1'b0));
      send_pixel(make_pixel(-32768, 0, 101, 1'b1));
      wait_for_results();
      write_register(CSR_REAL_IMAG_OFFSET, 16'h8000);
      send_pixel(make_pixel(-32768, -32768, 102, 1'b0));
      send_pixel(make_pixel(32767, -1, 103, 1'b1));
      wait_for_results();
   endtask

   task automatic test_mask_corners();
      write_register(CSR_COMPONENT_MASK, 16'(MASK_NONE));
      send_pixel(make_pixel(1000, -2000, 200, 1'b0));
      send_pixel(make_pixel(-3, 3, 201, 1'b1));
      wait_for_results();
      write_register(CSR_COMPONENT_MASK, 16'(MASK_POLAR));
      // out-of-range index must leave both registers alone
      write_register(CSR_UNUSED_INDEX, 16'h0000);
      send_pixel(make_pixel(-12345, 23456, 202, 1'b1));
      wait_for_results();
      write_register(CSR_COMPONENT_MASK, 16'(MASK_PHASE));
      send_pixel(make_pixel(20000, -20000, 203, 1'b0));
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
      int block;
      send_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      for (block = 0; block < 3; block++) begin
         write_register(CSR_COMPONENT_MASK, 16'($urandom_range(1, 15)));
         write_register(CSR_REAL_IMAG_OFFSET,
                        ($urandom_range(3) == 0) ? 16'h7FFF :
                        ($urandom_range(2) == 0) ? 16'h8000 : 16'($urandom));
         repeat (12) send_pixel(random_pixel());
         wait_for_results();
      end
   endtask

   // result side stalls long enough that the input queue fills behind it
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      write_register(CSR_COMPONENT_MASK, 16'(MASK_ALL));
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (40) send_pixel(random_pixel());
      wait_for_results();
   endtask

   always @(negedge clock)
      rsp_pop <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin : check_beat
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected, kind %0d value %0d",
                                      rsp_data.comp_kind, rsp_data.comp_value));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.comp_value !== want.comp_value)
               report_mismatch($sformatf("comp_value %0d, expected %0d (kind %0d)",
                                         rsp_data.comp_value, want.comp_value,
                                         want.comp_kind));
            if (rsp_data.comp_kind !== want.comp_kind)
               report_mismatch($sformatf("comp_kind %0d, expected %0d",
                                         rsp_data.comp_kind, want.comp_kind));
            if (rsp_data.series_out !== want.series_out)
               report_mismatch($sformatf("series_out %0d, expected %0d",
                                         rsp_data.series_out, want.series_out));
            if (rsp_data.image_end !== want.image_end)
               report_mismatch($sformatf("image_end %0b, expected %0b",
                                         rsp_data.image_end, want.image_end));
            if (rsp_data.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %0b, expected %0b",
                                         rsp_data.run_last, want.run_last));
         end
         beats_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (req_push && req_full)
         full_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out with %0d result beats outstanding", expected_beats.size());
         $display("[complex_pixel_component_extract_top] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_field_extremes();
      test_offset_extremes();
      test_mask_corners();
      test_random_traffic(18, 50);
      test_random_traffic(50, 18);
      test_random_traffic(0, 0);
      test_result_backpressure();
      $display("%0d pixels in, %0d result beats checked, %0d register writes",
               pixels_sent, beats_checked, csr_writes);
      $display("input held off by a full queue for %0d cycles", full_cycles);
      if (mismatch_count == 0)
         $display("[complex_pixel_component_extract_top] OK");
      else
         $display("[complex_pixel_component_extract_top] ERROR");
      $finish;
   end

endmodule
